// ===== rtl/acss_pkg.sv =====
package acss_pkg;

    // field widths
    localparam int CH_W     = 3;
    localparam int MASK_W   = 8;
    localparam int DMASK_W  = 4;
    localparam int GAIN_W   = 3;
    localparam int VREF_W   = 23;
    localparam int CODE_W   = 24;
    localparam int UV_W     = 25;
    localparam int MUX_W    = 8;
    localparam int PROD_W   = CODE_W + VREF_W;
    localparam int CFG_IDX_W = 3;

    // result tdata layout, lowest field first
    localparam int OUT_DATA_W = CH_W + CODE_W + UV_W + 1 + MUX_W + CH_W;

    // channel count default
    localparam int NUM_CHANNELS_DEF = 8;

    // full scale of the converter, 2^23 - 1
    localparam logic [VREF_W-1:0] FULL_SCALE = {VREF_W{1'b1}};

    // gain code that means unity gain
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 3'd7;

    // low nibble of the mux byte for single-ended inputs (negative input on common)
    localparam logic [3:0] MUX_SE_NEG = 4'h8;

    // input kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VREF_UV     = 3'd4;

    // reset values of the configuration registers
    localparam logic                 RST_DIFF_MODE   = 1'b0;
    localparam logic [MASK_W-1:0]    RST_SINGLE_MASK = 8'd1;
    localparam logic [DMASK_W-1:0]   RST_DIFF_MASK   = 4'd1;
    localparam logic [GAIN_W-1:0]    RST_GAIN_CODE   = 3'd5;
    localparam logic [VREF_W-1:0]    RST_VREF_UV     = 23'd2500000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // latch a new transaction and step the channel
        logic mul;    // magnitude times reference
        logic fold;   // gain shift and first fold of the full-scale divide
        logic fin;    // final correction, sign, load result register
    } acss_cmd_t;

endpackage

// ===== rtl/adc_channel_scan_sequencer.sv =====
// channel   direction  handshake               payload
// s_        in         s_tvalid / s_tready     tuser kind, tdata raw_code
// m_        out        m_tvalid / m_tready     tuser sample_valid, tdata result fields
// cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each transaction passes from acceptance to the result register through these steps: accept and
// channel step, one 24x23 multiply, the gain shift with the first full-scale fold, and
// the final correction. The scaling is split into these three short steps after the accept
// step; one item is in work at once.
// A new item is taken while a finished result waits; the last step stalls on m_tready.
// aresetn is synchronous, active low; it restores register defaults and channel 0.
// cfg_ready is always high; writes are expected only while the block is idle.
module adc_channel_scan_sequencer
    import acss_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CODE_W-1:0]     s_tdata,   // [23:0] raw_code
    input  logic                  s_tuser,   // [0] kind
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] sample_channel, [26:3] signed_code, [51:27] microvolts, [52] mux_write,
    // [60:53] mux_byte, [63:61] next_channel
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,   // [0] sample_valid
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VREF_W-1:0]     cfg_data
);

    acss_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // sequencing and output handshake
    acss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // channel selection, scaling and result register
    acss_dpath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .in_kind          (s_tuser),
        .in_raw_code      (s_tdata),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_sample_valid (m_tuser),
        .out_data         (m_tdata)
    );

endmodule

// ===== rtl/acss_ctrl.sv =====
module acss_ctrl
    import acss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output acss_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_FOLD = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   fin_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // finish only when the result register is free or being emptied
    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    assign cmd.load = s_tvalid && s_tready;
    assign cmd.mul  = (state_reg == ST_MUL);
    assign cmd.fold = (state_reg == ST_FOLD);
    assign cmd.fin  = fin_go;

    // sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_FOLD;
            ST_FOLD: state_next = ST_FIN;
            ST_FIN:  if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // result register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (fin_go) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/acss_dpath.sv =====
module acss_dpath
    import acss_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  acss_cmd_t             cmd,
    input  logic                  in_kind,
    input  logic [CODE_W-1:0]     in_raw_code,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VREF_W-1:0]     cfg_data,
    output logic                  out_sample_valid,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((1 << NUM_CHANNELS) - 1);

    // configuration registers
    logic                diff_mode_reg;
    logic [MASK_W-1:0]   single_mask_reg;
    logic [DMASK_W-1:0]  diff_mask_reg;
    logic [GAIN_W-1:0]   gain_code_reg;
    logic [VREF_W-1:0]   vref_reg;

    // scan state
    logic [CH_W-1:0]     cur_ch_reg, cur_ch_next;

    // per-transaction payload
    logic                kind_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [CH_W-1:0]     tag_reg;
    logic                mux_wr_reg, mux_wr_next;
    logic [MUX_W-1:0]    mux_byte_reg, mux_byte_next;
    logic [CH_W-1:0]     next_ch_reg;

    // scaling pipeline
    logic [PROD_W-1:0]   prod_reg;
    logic [CODE_W-1:0]   hi_reg;
    logic [CODE_W:0]     sum_reg;

    // result register
    logic                res_valid_reg;
    logic [CH_W-1:0]     res_ch_reg;
    logic [CODE_W-1:0]   res_code_reg;
    logic [UV_W-1:0]     res_uv_reg;
    logic                res_mux_wr_reg;
    logic [MUX_W-1:0]    res_mux_byte_reg;
    logic [CH_W-1:0]     res_next_reg;

    logic [MASK_W-1:0]   mask_act;
    logic [CH_W-1:0]     first_ch;
    logic [CH_W-1:0]     rr_ch;
    logic                rr_found;

    logic                neg;
    logic [CODE_W-1:0]   mag;
    logic [GAIN_W-1:0]   shamt;
    logic [PROD_W:0]     scaled;
    logic [1:0]          r1;
    logic [VREF_W:0]     r_tail;
    logic                adj;
    logic [UV_W-1:0]     quot;
    logic [UV_W-1:0]     uv;

    function automatic logic [MUX_W-1:0] mux_for(input logic [CH_W-1:0] ch,
                                                 input logic diff);
        logic [3:0] p;
        p = 4'({ch, 1'b0});
        if (diff) begin
            mux_for = {p, p + 4'd1};
        end else begin
            mux_for = {1'b0, ch, MUX_SE_NEG};
        end
    endfunction

    // active channel mask
    assign mask_act = (diff_mode_reg ? MASK_W'(diff_mask_reg) : single_mask_reg) & CH_MASK;

    // lowest enabled channel, zero when none
    always_comb begin
        first_ch = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (mask_act[i]) first_ch = CH_W'(i);
        end
    end

    // next enabled channel after the current one, round robin
    always_comb begin
        logic [CH_W:0] c;
        rr_ch    = cur_ch_reg;
        rr_found = 1'b0;
        c        = '0;
        for (int k = NUM_CHANNELS - 1; k >= 1; k--) begin
            c = {1'b0, cur_ch_reg} + (CH_W+1)'(k);
            if (c >= (CH_W+1)'(NUM_CHANNELS)) c = c - (CH_W+1)'(NUM_CHANNELS);
            if (mask_act[c[CH_W-1:0]]) begin
                rr_ch    = c[CH_W-1:0];
                rr_found = 1'b1;
            end
        end
    end

    // channel step for the incoming transaction
    always_comb begin
        cur_ch_next   = cur_ch_reg;
        mux_wr_next   = 1'b1;
        mux_byte_next = mux_for(first_ch, diff_mode_reg);
        if (in_kind == KIND_START) begin
            cur_ch_next = first_ch;
        end else begin
            mux_wr_next   = rr_found;
            mux_byte_next = rr_found ? mux_for(rr_ch, diff_mode_reg) : '0;
            if (rr_found) cur_ch_next = rr_ch;
        end
    end

    // configuration writes and scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_mode_reg   <= RST_DIFF_MODE;
            single_mask_reg <= RST_SINGLE_MASK;
            diff_mask_reg   <= RST_DIFF_MASK;
            gain_code_reg   <= RST_GAIN_CODE;
            vref_reg        <= RST_VREF_UV;
            cur_ch_reg      <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DIFF_MODE:   diff_mode_reg   <= cfg_data[0];
                    REG_SINGLE_MASK: single_mask_reg <= cfg_data[MASK_W-1:0];
                    REG_DIFF_MASK:   diff_mask_reg   <= cfg_data[DMASK_W-1:0];
                    REG_GAIN_CODE:   gain_code_reg   <= cfg_data[GAIN_W-1:0];
                    REG_VREF_UV:     vref_reg        <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load) cur_ch_reg <= cur_ch_next;
        end
    end

    // sign and magnitude of the code
    assign neg = code_reg[CODE_W-1];
    assign mag = neg ? (~code_reg + CODE_W'(1)) : code_reg;

    // gain shift amount
    assign shamt = (gain_code_reg == GAIN_UNITY) ? '0 : gain_code_reg;

    // 2*mag*vref / 2^gain, then x = hi*2^23 + lo = hi*(2^23-1) + (hi + lo)
    assign scaled = {prod_reg, 1'b0} >> shamt;

    // (hi + lo) = r1*2^23 + r0 = r1*(2^23-1) + (r1 + r0), r1 + r0 < 2*(2^23-1)
    assign r1     = sum_reg[CODE_W:VREF_W];
    assign r_tail = {1'b0, sum_reg[VREF_W-1:0]} + (VREF_W+1)'(r1);
    assign adj    = (r_tail >= {1'b0, FULL_SCALE});
    assign quot   = UV_W'(hi_reg) + UV_W'(r1) + UV_W'(adj);
    assign uv     = neg ? (~quot + UV_W'(1)) : quot;

    // payload and scaling pipeline
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg     <= in_kind;
            code_reg     <= (in_kind == KIND_START) ? '0 : in_raw_code;
            tag_reg      <= cur_ch_reg;
            mux_wr_reg   <= mux_wr_next;
            mux_byte_reg <= mux_byte_next;
            next_ch_reg  <= cur_ch_next;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(mag) * PROD_W'(vref_reg);
        end
        if (cmd.fold) begin
            hi_reg  <= scaled[PROD_W-1:VREF_W];
            sum_reg <= (CODE_W+1)'(scaled[PROD_W-1:VREF_W]) + (CODE_W+1)'(scaled[VREF_W-1:0]);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            res_valid_reg    <= (kind_reg == KIND_DATA);
            res_ch_reg       <= (kind_reg == KIND_DATA) ? tag_reg : '0;
            res_code_reg     <= code_reg;
            res_uv_reg       <= uv;
            res_mux_wr_reg   <= mux_wr_reg;
            res_mux_byte_reg <= mux_byte_reg;
            res_next_reg     <= next_ch_reg;
        end
    end

    assign out_sample_valid = res_valid_reg;
    assign out_data = {res_next_reg, res_mux_byte_reg, res_mux_wr_reg,
                       res_uv_reg, res_code_reg, res_ch_reg};

endmodule
